FILE: sv/d2i_pkg.sv
// Package: shared types and constants for the double to int32 converter.
package d2i_pkg;
   localparam logic [63:0] PREFIX_WORD  = 64'hfff8_0000_0000_0000;
   localparam logic [31:0] INT_MAX_MAG  = 32'h7fff_ffff;
   localparam logic [31:0] INT_MIN_MAG  = 32'h8000_0000;
   localparam logic [10:0] EXP_SPECIAL  = 11'h7ff;
   localparam logic [10:0] EXP_BIAS_INT = 11'd1075;

   typedef enum logic [1:0] {
      RM_NEAREST = 2'd0,
      RM_ZERO    = 2'd1,
      RM_PLUS    = 2'd2,
      RM_MINUS   = 2'd3
   } round_mode_type;

   typedef enum logic {
      ACT_MODE  = 1'b0,
      ACT_TRUNC = 1'b1
   } action_type;

   typedef struct packed {
      logic [63:0] result_word;
      logic        invalid_conversion;
      logic        inexact;
      logic        rounded_up;
   } result_type;
endpackage

FILE: sv/d2i_req_if.sv
// Interface: input item channel.
interface d2i_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [63:0] operand_bits;
   modport source (output valid, output action, output operand_bits, input ready);
   modport sink   (input valid, input action, input operand_bits, output ready);
endinterface

FILE: sv/d2i_rsp_if.sv
// Interface: result item channel.
interface d2i_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_word;
   logic        invalid_conversion;
   logic        inexact;
   logic        rounded_up;
   modport source (output valid, output result_word, output invalid_conversion,
                   output inexact, output rounded_up, input ready);
   modport sink   (input valid, input result_word, input invalid_conversion,
                   input inexact, input rounded_up, output ready);
endinterface

FILE: sv/d2i_csr_if.sv
// Interface: rounding mode register write channel.
interface d2i_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/double_to_int32_convert_unit.sv
// Double to int32 converter: registered item in, one conversion, skid-free result register.
// Takes one item per cycle unless the result register is full and not taken; an item passes
// the input register, then the result register. The rate is set by the single-pass
// conversion between those registers; the input stays ready whenever the result
// register is empty or being taken. Rounding mode writes are registered, then take effect.
module double_to_int32_convert_unit (
   input  logic       clock,
   input  logic       reset,
   d2i_req_if.sink    req,
   d2i_rsp_if.source  rsp,
   d2i_csr_if.sink    csr
);
   import d2i_pkg::*;

   round_mode_type rmode_ff;
   logic           in_valid_ff, out_valid_ff;
   logic           action_ff;
   logic [63:0]    operand_ff;
   result_type     res_in, res_ff;
   round_mode_type eff_mode;
   logic           advance;

   assign csr.ready = 1'b1;
   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = advance || !in_valid_ff;
   assign eff_mode  = (action_ff == ACT_TRUNC) ? RM_ZERO : rmode_ff;

   d2i_convert u_conv (.operand_bits(operand_ff), .mode(eff_mode), .result(res_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         rmode_ff     <= RM_NEAREST;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr.valid)
            rmode_ff <= round_mode_type'(csr.data);
         if (advance)
            out_valid_ff <= in_valid_ff;
         if (req.ready)
            in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         action_ff  <= req.action;
         operand_ff <= req.operand_bits;
      end
      if (advance && in_valid_ff)
         res_ff <= res_in;
   end

   assign rsp.valid              = out_valid_ff;
   assign rsp.result_word        = res_ff.result_word;
   assign rsp.invalid_conversion = res_ff.invalid_conversion;
   assign rsp.inexact            = res_ff.inexact;
   assign rsp.rounded_up         = res_ff.rounded_up;
endmodule

FILE: sv/d2i_convert.sv
// Combinational conversion of one double pattern to a saturated int32 result.
module d2i_convert (
   input  logic [63:0]              operand_bits,
   input  d2i_pkg::round_mode_type  mode,
   output d2i_pkg::result_type      result
);
   import d2i_pkg::*;

   logic        neg;
   logic [10:0] ex;
   logic [52:0] m;
   logic [11:0] k;
   logic [5:0]  sh;
   logic [63:0] wide;
   logic [63:0] ip;
   logic        rbit, sticky, frac, inc, lsb, sat;
   logic [32:0] mag;
   logic [31:0] value;

   always_comb begin
      neg = operand_bits[63];
      ex  = operand_bits[62:52];
      m   = {(ex != 11'd0), operand_bits[51:0]};
      // shift right count k = 1075 - max(ex,1); k >= 64 leaves no integer part
      k   = {1'b0, EXP_BIAS_INT} - {1'b0, (ex == 11'd0) ? 11'd1 : ex};
      sh  = (k > 12'd63) ? 6'd63 : k[5:0];
      // fraction bits of m left-aligned in 64 bits, MSB is the half bit
      wide   = 64'({64'd0, m} << (7'd64 - {1'b0, sh}));
      ip     = (k > 12'd63) ? 64'd0 : ({11'd0, m} >> sh);
      rbit   = (k > 12'd63) ? 1'b0 : wide[63];
      sticky = (k > 12'd63) ? (m != 53'd0) : (wide[62:0] != 63'd0);
      frac   = rbit | sticky;
      lsb    = ip[0];
      case (mode)
         RM_NEAREST: inc = rbit & (sticky | lsb);
         RM_PLUS:    inc = frac & ~neg;
         RM_MINUS:   inc = frac & neg;
         default:    inc = 1'b0;
      endcase
      mag = ip[32:0] + {32'd0, inc};
      sat = (ex == EXP_SPECIAL) || (ex >= EXP_BIAS_INT) || (ip[63:32] != 32'd0)
            || (!neg && mag > {1'b0, INT_MAX_MAG}) || (neg && mag > {1'b0, INT_MIN_MAG});
      if (ex == EXP_SPECIAL)
         value = (operand_bits[51:0] != 52'd0 || neg) ? INT_MIN_MAG : INT_MAX_MAG;
      else if (sat)
         value = neg ? INT_MIN_MAG : INT_MAX_MAG;
      else
         value = neg ? (32'd0 - mag[31:0]) : mag[31:0];
      result.result_word        = PREFIX_WORD | {31'd0, (value == 32'd0) && neg, value};
      result.invalid_conversion = sat;
      result.inexact            = !sat && frac;
      result.rounded_up         = !sat && inc;
   end
endmodule

FILE: sv/d2i_checker.sv
// Checker: port-level properties of the converter, bound to the top level.
module d2i_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_result_word,
   input logic        rsp_invalid_conversion,
   input logic        rsp_inexact,
   input logic        rsp_rounded_up
);
   a_prefix: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_result_word[63:51] == 13'h1fff)
      else $error("prefix missing");
   a_inv_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invalid_conversion |-> !rsp_inexact && !rsp_rounded_up)
      else $error("flags on invalid");
   a_up_inexact: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rounded_up |-> rsp_inexact)
      else $error("rounded up but exact");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_word))
      else $error("stalled result changed");
endmodule

bind double_to_int32_convert_unit d2i_checker u_chk (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_result_word(rsp.result_word), .rsp_invalid_conversion(rsp.invalid_conversion),
   .rsp_inexact(rsp.inexact), .rsp_rounded_up(rsp.rounded_up));
